/* src/lpht_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and codes for the linear probing hash table core.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int SLOT_COUNT_DEF = 1024;
    localparam int VALUE_BITS_DEF = 64;

    localparam logic [3:0] SIZE_LOG2_RST = 4'd10;

    // command codes
    localparam logic [1:0] CMD_GET = 2'd0;
    localparam logic [1:0] CMD_SET = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;
    localparam logic [1:0] CMD_NOP = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    // slot marks
    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_FULL  = 2'd1;
    localparam logic [1:0] MARK_TOMB  = 2'd2;

    typedef enum logic [1:0] {
        WR_NONE   = 2'd0,
        WR_VALUE  = 2'd1,
        WR_TOMB   = 2'd2,
        WR_INSERT = 2'd3
    } wr_kind_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] key_id;
        logic [31:0] key_hash;
        logic [63:0] value_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        flag;
        logic [63:0] value_out;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic       clr_we;
        logic       load_item;
        logic       fetch;
        logic       step;
        logic       set_res;
        logic [1:0] res_status;
        logic       res_flag;
        logic       res_take_val;
        wr_kind_t   wr_kind;
        logic       count_inc;
        logic       push;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       clr_last;
        logic [1:0] cmd;
        logic       over_load;
        logic       used_zero;
        logic       hit;
        logic       empty;
        logic       last;
        logic       have_slot;
        logic       ins_empty;
        logic       out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

/* src/lpht_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_datapath
// Slot memories, probe address walk, occupancy count, size register and
// result/output registers.
// ----------------------------------------------------------------------------
module lpht_datapath import lpht_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire dp_cmd_t   cmd,
    output dp_stat_t       stat,
    input  wire logic      cfg_we,
    input  wire logic [3:0] cfg_data,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    localparam int IDX_W   = $clog2(SLOT_COUNT);
    localparam int CNT_W   = IDX_W + 1;
    localparam int CHK_W   = IDX_W + 4;
    localparam int MAX_LOG = $clog2(SLOT_COUNT + 1) - 1;

    logic [1:0]            mark_mem [SLOT_COUNT];
    logic [31:0]           key_mem  [SLOT_COUNT];
    logic [VALUE_BITS-1:0] val_mem  [SLOT_COUNT];

    logic [3:0]            size_log2_reg;
    logic [CNT_W-1:0]      used_count_reg;
    logic [IDX_W-1:0]      clr_idx_reg;
    logic                  m_valid_reg;

    in_item_t              item_reg;
    logic [IDX_W-1:0]      addr_reg;
    logic [IDX_W-1:0]      cur_idx_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  tomb_seen_reg;
    logic [IDX_W-1:0]      tomb_idx_reg;
    logic [1:0]            rd_mark_reg;
    logic [31:0]           rd_key_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;
    out_item_t             res_reg;
    out_item_t             m_data_reg;

    logic [4:0]            size_eff;
    logic [CNT_W-1:0]      cap;
    logic [IDX_W-1:0]      mask;
    logic [CHK_W-1:0]      load_lhs;
    logic [CHK_W-1:0]      load_rhs;
    logic                  is_tomb;
    logic [IDX_W-1:0]      ins_idx;
    logic                  mark_we;
    logic [IDX_W-1:0]      mark_addr;
    logic [1:0]            mark_wdata;
    logic                  val_we;
    logic [IDX_W-1:0]      val_addr;

    // active size clamped to 1..log2(SLOT_COUNT)
    always_comb begin
        if (size_log2_reg == 4'd0) begin
            size_eff = 5'd1;
        end else if ({1'b0, size_log2_reg} > 5'(MAX_LOG)) begin
            size_eff = 5'(MAX_LOG);
        end else begin
            size_eff = {1'b0, size_log2_reg};
        end
    end

    assign cap  = CNT_W'(1) << size_eff;
    assign mask = IDX_W'(cap - CNT_W'(1));

    // reject when 4 * (used + 1) > 3 * cap
    assign load_lhs = (CHK_W'(used_count_reg) + CHK_W'(1)) << 2;
    assign load_rhs = (CHK_W'(cap) << 1) + CHK_W'(cap);

    assign is_tomb = (rd_mark_reg == MARK_TOMB);
    assign ins_idx = tomb_seen_reg ? tomb_idx_reg : cur_idx_reg;

    always_comb begin
        stat.clr_last  = (clr_idx_reg == IDX_W'(SLOT_COUNT - 1));
        stat.cmd       = item_reg.command;
        stat.over_load = (load_lhs > load_rhs);
        stat.used_zero = (used_count_reg == '0);
        stat.hit       = (rd_mark_reg == MARK_FULL) && (rd_key_reg == item_reg.key_id);
        stat.empty     = (rd_mark_reg == MARK_EMPTY);
        stat.last      = (count_reg == cap - CNT_W'(1));
        stat.have_slot = tomb_seen_reg || is_tomb || stat.empty;
        stat.ins_empty = stat.empty && !tomb_seen_reg;
        stat.out_free  = !m_valid_reg || m_ready;
    end

    // memory write port steering
    always_comb begin
        mark_we    = 1'b0;
        mark_addr  = cur_idx_reg;
        mark_wdata = MARK_FULL;
        val_we     = 1'b0;
        val_addr   = cur_idx_reg;
        if (cmd.clr_we) begin
            mark_we    = 1'b1;
            mark_addr  = clr_idx_reg;
            mark_wdata = MARK_EMPTY;
        end else begin
            case (cmd.wr_kind)
                WR_VALUE: begin
                    val_we = 1'b1;
                end
                WR_TOMB: begin
                    mark_we    = 1'b1;
                    mark_wdata = MARK_TOMB;
                end
                WR_INSERT: begin
                    mark_we   = 1'b1;
                    mark_addr = ins_idx;
                    val_we    = 1'b1;
                    val_addr  = ins_idx;
                end
                default: begin
                    mark_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_addr] <= mark_wdata;
        end
        if (cmd.fetch) begin
            rd_mark_reg <= mark_mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_kind == WR_INSERT) begin
            key_mem[ins_idx] <= item_reg.key_id;
        end
        if (cmd.fetch) begin
            rd_key_reg <= key_mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[val_addr] <= item_reg.value_in[VALUE_BITS-1:0];
        end
        if (cmd.fetch) begin
            rd_val_reg <= val_mem[addr_reg];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_log2_reg  <= SIZE_LOG2_RST;
            used_count_reg <= '0;
            clr_idx_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                size_log2_reg <= cfg_data;
            end
            if (cmd.count_inc) begin
                used_count_reg <= used_count_reg + CNT_W'(1);
            end
            if (cmd.clr_we) begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
            if (cmd.push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // probe walk and payload
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg      <= s_data;
            addr_reg      <= s_data.key_hash[IDX_W-1:0] & mask;
            count_reg     <= '0;
            tomb_seen_reg <= 1'b0;
        end else begin
            if (cmd.fetch) begin
                cur_idx_reg <= addr_reg;
                addr_reg    <= (addr_reg + IDX_W'(1)) & mask;
            end
            if (cmd.step) begin
                count_reg <= count_reg + CNT_W'(1);
                if (is_tomb && !tomb_seen_reg) begin
                    tomb_seen_reg <= 1'b1;
                    tomb_idx_reg  <= cur_idx_reg;
                end
            end
        end
        if (cmd.set_res) begin
            res_reg.status    <= cmd.res_status;
            res_reg.flag      <= cmd.res_flag;
            res_reg.value_out <= cmd.res_take_val ? 64'(rd_val_reg) : 64'd0;
        end
        if (cmd.push) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (!m_valid_reg || m_ready))
        else $error("result pushed over an untaken word");

    a_load_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (CHK_W'(used_count_reg) << 2) <= CHK_W'(3 * SLOT_COUNT))
        else $error("occupancy above three quarters of capacity");

endmodule
`default_nettype wire

/* src/lpht_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_ctrl
// Sequencer: reset clear sweep, item intake, probe walk decisions and
// result hand-off.
// ----------------------------------------------------------------------------
module lpht_ctrl import lpht_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_PROBE = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next       = state_reg;
        cmd              = '0;
        cmd.wr_kind      = WR_NONE;
        cmd.res_status   = STATUS_OK;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_we = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_FETCH;
                end
            end
            ST_FETCH: begin
                // early answers that need no probe
                if (stat.cmd == CMD_NOP) begin
                    cmd.set_res = 1'b1;
                    state_next  = ST_DONE;
                end else if (stat.cmd == CMD_SET && stat.over_load) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = STATUS_FULL;
                    state_next     = ST_DONE;
                end else if (stat.cmd == CMD_DEL && stat.used_zero) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = STATUS_MISS;
                    state_next     = ST_DONE;
                end else begin
                    cmd.fetch  = 1'b1;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (stat.hit) begin
                    cmd.set_res = 1'b1;
                    state_next  = ST_DONE;
                    case (stat.cmd)
                        CMD_GET: begin
                            cmd.res_flag     = 1'b1;
                            cmd.res_take_val = 1'b1;
                        end
                        CMD_SET: begin
                            cmd.wr_kind = WR_VALUE;
                        end
                        CMD_DEL: begin
                            cmd.wr_kind  = WR_TOMB;
                            cmd.res_flag = 1'b1;
                        end
                        default: begin
                            cmd.res_flag = 1'b0;
                        end
                    endcase
                end else if (stat.empty || stat.last) begin
                    cmd.set_res = 1'b1;
                    state_next  = ST_DONE;
                    if (stat.cmd == CMD_SET) begin
                        if (stat.have_slot) begin
                            cmd.wr_kind   = WR_INSERT;
                            cmd.count_inc = stat.ins_empty;
                            cmd.res_flag  = 1'b1;
                        end else begin
                            cmd.res_status = STATUS_FULL;
                        end
                    end else begin
                        cmd.res_status = STATUS_MISS;
                    end
                end else begin
                    cmd.fetch = 1'b1;
                    cmd.step  = 1'b1;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_FETCH))
        else $error("accepted word did not start a lookup");

    a_count_on_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.count_inc |-> (cmd.wr_kind == WR_INSERT))
        else $error("occupancy bumped without an insert");

    a_no_write_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (cmd.wr_kind == WR_NONE && !s_ready))
        else $error("table access during clear sweep");

endmodule
`default_nettype wire

/* src/linear_probe_hash_table_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing key/value table with linear probing and tombstones.
//
// s_* channel takes one word per command: get, set, delete or nop with key
// id, precomputed hash and value. m_* channel returns one word per command:
// status, flag and the value found by a get. cfg_* writes size_log2, which
// sets the probe wrap mask; write it only while the core is idle.
// An accepted command goes from FETCH through one PROBE step per slot
// probed (one slot per cycle from the slot memories, whose read port
// is registered) to DONE; commands answered without a probe skip PROBE. Next
// word is taken the cycle after the result is handed to the output
// register, so no new word is taken while a command is in progress.
// After reset the slot marks are swept to empty, one slot per cycle,
// with s_ready low; cfg writes are taken during the sweep.
// When m_ready is low the finished word waits in the output register and
// the core takes and probes the next command, holding its result until the
// output register frees up.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core import lpht_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [3:0] cfg_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_item_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    lpht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lpht_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire
